// File: rtl/vfd_spi_command_sequencer_core_assert.svh
// Assertion macros for the display sequencer checker.
// No dependencies; included by the checker file only.
`ifndef VFD_SPI_COMMAND_SEQUENCER_CORE_ASSERT_SVH
`define VFD_SPI_COMMAND_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define VFDSQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("vfdsq assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define VFDSQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("vfdsq assertion failed");

`endif

// File: rtl/vfdsq_pkg.sv
// Shared types and constants for the display command sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package vfdsq_pkg;

  // Operation codes of an input beat
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_INIT = 2'd1;
  localparam logic [1:0] OP_DISP = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_GAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS     = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // Controller command bytes
  localparam logic [7:0] CMD_DIGITS = 8'hE0;
  localparam logic [7:0] CMD_BRIGHT = 8'hE4;
  localparam logic [7:0] CMD_TEXT   = 8'h20;
  localparam logic [7:0] CMD_SHOW   = 8'hE8;

  // Register reset values
  localparam logic [7:0]  HALF_BIT_RST   = 8'd1;
  localparam logic [7:0]  BYTE_GAP_RST   = 8'd5;
  localparam logic [15:0] RESET_TICKS_RST = 16'd5000;
  localparam logic [7:0]  BRIGHTNESS_RST = 8'hFF;
  localparam logic [2:0]  DIGITS_RST     = 3'h7;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char0;
    logic [7:0] char1;
    logic [7:0] char2;
    logic [7:0] char3;
    logic [7:0] char4;
    logic [7:0] char5;
    logic [7:0] char6;
    logic [7:0] char7;
  } in_t;

  typedef struct packed {
    logic sck;
    logic mosi;
    logic cs_n;
    logic reset_n;
    logic busy_res;
    logic rejected;
  } out_t;

  typedef struct packed {
    logic [7:0]  half_bit_ticks;
    logic [7:0]  byte_gap_ticks;
    logic [15:0] reset_ticks;
    logic [7:0]  brightness;
    logic [2:0]  digit_count_minus_one;
  } cfg_t;

endpackage

// File: rtl/vfd_spi_command_sequencer_core.sv
// Registers: an input beat passes the input register, then the result register.
// Throughput: one beat per cycle unless the result beat is stalled; the
// single-pass next-state logic of vfdsq_fsm sits between the two registers and
// updates the sequencer state once per beat. Reset: asynchronous, active low;
// fsm pins go to sck 1, mosi 0, cs_n 1, reset_n 1; the fsm idles and config resets.
`timescale 1ns / 1ps

module vfd_spi_command_sequencer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  vfdsq_pkg::in_t                   in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output vfdsq_pkg::out_t                  out_data_o,
  input  logic                             cfg_we_i,
  input  logic [vfdsq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vfdsq_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import vfdsq_pkg::*;

  logic in_valid_q;
  in_t  in_data_q;
  logic out_valid_q;
  out_t out_data_q;
  logic step;
  cfg_t cfg;
  out_t res;

  // Process the held beat when the result register is free or draining
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  vfdsq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  vfdsq_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/vfdsq_cfg.sv
// Configuration register bank of the display sequencer.
// Depends on vfdsq_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module vfdsq_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vfdsq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vfdsq_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output vfdsq_pkg::cfg_t               cfg_o
);
  import vfdsq_pkg::*;

  cfg_t cfg_q;

  // Take a write at the addressed register; drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit_ticks        <= HALF_BIT_RST;
      cfg_q.byte_gap_ticks        <= BYTE_GAP_RST;
      cfg_q.reset_ticks           <= RESET_TICKS_RST;
      cfg_q.brightness            <= BRIGHTNESS_RST;
      cfg_q.digit_count_minus_one <= DIGITS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_HALF_BIT:   cfg_q.half_bit_ticks        <= cfg_wdata_i[7:0];
        REG_BYTE_GAP:   cfg_q.byte_gap_ticks        <= cfg_wdata_i[7:0];
        REG_RESET:      cfg_q.reset_ticks           <= cfg_wdata_i[15:0];
        REG_BRIGHTNESS: cfg_q.brightness            <= cfg_wdata_i[7:0];
        REG_DIGITS:     cfg_q.digit_count_minus_one <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/vfdsq_fsm.sv
// Sequencer state, character store and per-beat next-state logic.
// Depends on vfdsq_pkg for in_t, out_t, cfg_t, op codes and command bytes.
`timescale 1ns / 1ps

module vfdsq_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  vfdsq_pkg::in_t    item_i,
  input  vfdsq_pkg::cfg_t   cfg_i,
  output vfdsq_pkg::out_t   res_o
);
  import vfdsq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RESET, ST_INIT_A, ST_INIT_B, ST_DISP, ST_DISP_END
  } step_e;

  typedef enum logic [1:0] {
    PH_START, PH_LOW, PH_HIGH, PH_GAP
  } phase_e;

  step_e       step_q, step_d;
  phase_e      phase_q, phase_d;
  logic [3:0]  byte_q, byte_d;
  logic [2:0]  bit_q, bit_d;
  logic [15:0] wait_q, wait_d;
  logic        sck_q, sck_d, mosi_q, mosi_d, cs_n_q, cs_n_d, rst_n_q, rst_n_d;
  logic [7:0]  char_q [8];
  logic        load_chars;
  logic        rejected;

  logic        do_begin;
  logic        do_end;
  logic [3:0]  byte_inc;
  logic [3:0]  byte_m1;
  logic [3:0]  frame_len;
  logic [7:0]  frame_byte;
  logic [15:0] half_len;
  logic        is_req;

  assign half_len = (cfg_i.half_bit_ticks == 8'd0) ? 16'd1 : {8'd0, cfg_i.half_bit_ticks};
  assign byte_inc = byte_q + 4'd1;
  assign is_req   = (item_i.operation == OP_INIT) || (item_i.operation == OP_DISP);

  // Bytes in the frame of the current step
  always_comb begin
    unique case (step_q)
      ST_INIT_A, ST_INIT_B: frame_len = 4'd2;
      ST_DISP:              frame_len = 4'd9;
      default:              frame_len = 4'd1;
    endcase
  end

  // Work out the next state for one beat
  always_comb begin
    step_d     = step_q;
    phase_d    = phase_q;
    byte_d     = byte_q;
    bit_d      = bit_q;
    wait_d     = wait_q;
    sck_d      = sck_q;
    mosi_d     = mosi_q;
    cs_n_d     = cs_n_q;
    rst_n_d    = rst_n_q;
    rejected   = 1'b0;
    load_chars = 1'b0;
    do_begin   = 1'b0;
    do_end     = 1'b0;
    byte_m1    = 4'd0;
    frame_byte = 8'd0;

    if (item_i.operation == OP_TICK) begin
      unique case (step_q)
        ST_IDLE: ;
        ST_RESET: begin
          if (wait_q > 16'd1) begin
            wait_d = wait_q - 16'd1;
          end else begin
            wait_d  = 16'd0;
            rst_n_d = 1'b1;
            step_d  = ST_INIT_A;
            phase_d = PH_START;
          end
        end
        default: begin
          if (phase_q == PH_START) begin
            cs_n_d   = 1'b0;
            byte_d   = 4'd0;
            bit_d    = 3'd0;
            do_begin = 1'b1;
          end else if (wait_q > 16'd1) begin
            wait_d = wait_q - 16'd1;
          end else begin
            wait_d = 16'd0;
            unique case (phase_q)
              PH_LOW: begin
                sck_d   = 1'b1;
                wait_d  = half_len;
                phase_d = PH_HIGH;
              end
              PH_HIGH: begin
                if (bit_q != 3'd7) begin
                  bit_d    = bit_q + 3'd1;
                  do_begin = 1'b1;
                end else if (cfg_i.byte_gap_ticks != 8'd0) begin
                  wait_d  = {8'd0, cfg_i.byte_gap_ticks};
                  phase_d = PH_GAP;
                end else begin
                  do_end = 1'b1;
                end
              end
              default: do_end = 1'b1;
            endcase
          end
        end
      endcase

      // Close the byte: next byte of the frame, or end of the frame
      if (do_end) begin
        bit_d = 3'd0;
        if (byte_inc < frame_len) begin
          byte_d   = byte_inc;
          do_begin = 1'b1;
        end else begin
          cs_n_d  = 1'b1;
          mosi_d  = 1'b0;
          byte_d  = 4'd0;
          phase_d = PH_START;
          wait_d  = 16'd0;
          priority if (step_q == ST_INIT_A) begin
            step_d = ST_INIT_B;
          end else if (step_q == ST_DISP) begin
            step_d = ST_DISP_END;
          end else begin
            step_d = ST_IDLE;
          end
        end
      end
    end else if (is_req) begin
      if (step_q != ST_IDLE) begin
        rejected = 1'b1;
      end else begin
        sck_d   = 1'b1;
        mosi_d  = 1'b0;
        cs_n_d  = 1'b1;
        rst_n_d = 1'b1;
        byte_d  = 4'd0;
        bit_d   = 3'd0;
        phase_d = PH_START;
        if (item_i.operation == OP_INIT) begin
          rst_n_d = 1'b0;
          wait_d  = (cfg_i.reset_ticks == 16'd0) ? 16'd1 : cfg_i.reset_ticks;
          step_d  = ST_RESET;
        end else begin
          load_chars = 1'b1;
          wait_d     = 16'd0;
          step_d     = ST_DISP;
        end
      end
    end

    // Start a bit: pick the byte at the chosen position, clock low, data set
    if (do_begin) begin
      byte_m1 = byte_d - 4'd1;
      unique case (step_q)
        ST_INIT_A: frame_byte = (byte_d == 4'd0) ? CMD_DIGITS
                                                 : {5'd0, cfg_i.digit_count_minus_one};
        ST_INIT_B: frame_byte = (byte_d == 4'd0) ? CMD_BRIGHT : cfg_i.brightness;
        ST_DISP:   frame_byte = (byte_d == 4'd0) ? CMD_TEXT : char_q[byte_m1[2:0]];
        default:   frame_byte = CMD_SHOW;
      endcase
      sck_d   = 1'b0;
      mosi_d  = frame_byte[bit_d];
      wait_d  = half_len;
      phase_d = PH_LOW;
    end
  end

  // Hold sequencer control state and pin levels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_IDLE;
      phase_q <= PH_START;
      byte_q  <= 4'd0;
      bit_q   <= 3'd0;
      wait_q  <= 16'd0;
      sck_q   <= 1'b1;
      mosi_q  <= 1'b0;
      cs_n_q  <= 1'b1;
      rst_n_q <= 1'b1;
    end else if (step_i) begin
      step_q  <= step_d;
      phase_q <= phase_d;
      byte_q  <= byte_d;
      bit_q   <= bit_d;
      wait_q  <= wait_d;
      sck_q   <= sck_d;
      mosi_q  <= mosi_d;
      cs_n_q  <= cs_n_d;
      rst_n_q <= rst_n_d;
    end
  end

  // Character store, loaded by an accepted display request
  always_ff @(posedge clk_i) begin
    if (step_i && load_chars) begin
      char_q[0] <= item_i.char0;
      char_q[1] <= item_i.char1;
      char_q[2] <= item_i.char2;
      char_q[3] <= item_i.char3;
      char_q[4] <= item_i.char4;
      char_q[5] <= item_i.char5;
      char_q[6] <= item_i.char6;
      char_q[7] <= item_i.char7;
    end
  end

  assign res_o.sck      = sck_d;
  assign res_o.mosi     = mosi_d;
  assign res_o.cs_n     = cs_n_d;
  assign res_o.reset_n  = rst_n_d;
  assign res_o.busy_res = (step_d != ST_IDLE);
  assign res_o.rejected = rejected;

endmodule

// File: rtl/vfdsq_checker.sv
// Port-level checker for the display sequencer, bound to the top level.
// Depends on vfdsq_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "vfd_spi_command_sequencer_core_assert.svh"

module vfdsq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input vfdsq_pkg::out_t                  out_data_o
);
  import vfdsq_pkg::*;

  logic idle_pins;
  logic stalled;

  assign idle_pins = out_data_o.sck && !out_data_o.mosi && out_data_o.cs_n &&
                     out_data_o.reset_n;
  assign stalled   = out_valid_o && !out_ready_i;

  // A stalled result beat holds
  `VFDSQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_o && $stable(out_data_o))
  // A rejected request can only come while a sequence runs
  `VFDSQ_ASSERT_NOW(a_rej_busy, clk_i, rst_ni, out_valid_o && out_data_o.rejected,
                    out_data_o.busy_res)
  // With no sequence running the pins sit at their idle levels
  `VFDSQ_ASSERT_NOW(a_idle_pins, clk_i, rst_ni, out_valid_o && !out_data_o.busy_res,
                    idle_pins)
  // Input backpressure only while a result beat is pending
  `VFDSQ_ASSERT_NOW(a_ready_gap, clk_i, rst_ni, !in_ready_o, out_valid_o)

endmodule

bind vfd_spi_command_sequencer_core vfdsq_checker u_vfdsq_checker (.*);
